// ===== rtl/tsa_pkg.sv =====
// Shared types, constants and command codes of the touch slot allocator.
`default_nettype none
package tsa_pkg;

  localparam int unsigned SLOTS       = 10;
  localparam int unsigned MAX_RESULTS = 20;
  localparam int unsigned MAX_EXPIRE  = MAX_RESULTS / 2;
  localparam int unsigned CNT_W       = $clog2(MAX_EXPIRE + 1);

  localparam int unsigned KIND_W = 3;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned RES_W  = 2;
  localparam int unsigned OP_W   = 3;

  localparam logic [TICK_W-1:0] EXPIRE_RESET = 16'd1000;

  localparam logic [KIND_W-1:0] KIND_ACQUIRE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFRESH    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY_ID   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY_SLOT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK       = 3'd5;

  localparam logic [RES_W-1:0] RES_RESPONSE = 2'd0;
  localparam logic [RES_W-1:0] RES_SELECT   = 2'd1;
  localparam logic [RES_W-1:0] RES_UP       = 2'd2;

  localparam logic [OP_W-1:0] OP_NONE       = 3'd0;
  localparam logic [OP_W-1:0] OP_EXEC       = 3'd1;
  localparam logic [OP_W-1:0] OP_TICK_START = 3'd2;
  localparam logic [OP_W-1:0] OP_EMIT_SEL   = 3'd3;
  localparam logic [OP_W-1:0] OP_EMIT_UP    = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   identifier;
    logic [SLOT_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [RES_W-1:0]  result_kind;
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic            load_req;
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              exp_any;
    logic              out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tsa_ctrl.sv =====
// Controller state machine sequencing requests and tick event emission.
`default_nettype none
module tsa_ctrl
  import tsa_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_UP   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.op       = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.kind == KIND_TICK) begin
          cmd_o.op = OP_TICK_START;
          state_d  = ST_SCAN;
        end else if (sts_i.out_free) begin
          cmd_o.op = OP_EXEC;
          state_d  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!sts_i.exp_any) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT_SEL;
          state_d  = ST_UP;
        end
      end
      ST_UP: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_EMIT_UP;
          state_d  = ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tsa_dp.sv =====
// Datapath: slot table, identifier match, expiry mask and output register.
`default_nettype none
module tsa_dp
  import tsa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TICK_W-1:0] cfg_wdata_i,
  input  wire req_t              in_req_i,
  input  wire dp_cmd_t           cmd_i,
  output dp_sts_t                sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rsp_t                   out_rsp_o
);

  req_t              req_q;
  logic [TICK_W-1:0] expire_q;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [SLOTS-1:0]  exp_q, exp_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ID_W-1:0]   owner_q [SLOTS];
  logic [ID_W-1:0]   owner_d [SLOTS];
  logic [TICK_W-1:0] ticks_q [SLOTS];
  logic [TICK_W-1:0] ticks_d [SLOTS];
  logic              out_valid_q, out_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic              hit, any_free, slot_reg, last_up;
  logic [SLOT_W-1:0] hit_idx, free_idx, sel_idx;
  logic [SLOTS-1:0]  exp_rest;
  logic              out_free;

  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    any_free = 1'b0;
    free_idx = '0;
    sel_idx  = '0;
    slot_reg = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (used_q[i] && owner_q[i] == req_q.identifier) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!used_q[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (exp_q[i]) begin
        sel_idx = SLOT_W'(i);
      end
      if (req_q.slot_index == SLOT_W'(i) && used_q[i]) begin
        slot_reg = 1'b1;
      end
    end
  end

  always_comb begin
    exp_rest = exp_q;
    for (int i = 0; i < SLOTS; i++) begin
      if (sel_idx == SLOT_W'(i)) begin
        exp_rest[i] = 1'b0;
      end
    end
    last_up = (exp_rest == '0) || (cnt_q == CNT_W'(MAX_EXPIRE - 1));
  end

  assign out_free       = !out_valid_q || out_ready_i;
  assign sts_o.kind     = req_q.kind;
  assign sts_o.exp_any  = |exp_q;
  assign sts_o.out_free = out_free;

  always_comb begin
    used_d      = used_q;
    exp_d       = exp_q;
    cnt_d       = cnt_q;
    owner_d     = owner_q;
    ticks_d     = ticks_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rsp_d       = rsp_q;
    case (cmd_i.op)
      OP_EXEC: begin
        rsp_d.result_kind = RES_RESPONSE;
        rsp_d.slot        = '0;
        rsp_d.ok          = 1'b0;
        rsp_d.last        = 1'b1;
        out_valid_d       = 1'b1;
        case (req_q.kind)
          KIND_ACQUIRE: begin
            if (hit) begin
              rsp_d.slot = hit_idx;
              rsp_d.ok   = 1'b1;
            end else if (any_free) begin
              rsp_d.slot = free_idx;
              rsp_d.ok   = 1'b1;
              for (int i = 0; i < SLOTS; i++) begin
                if (free_idx == SLOT_W'(i)) begin
                  used_d[i]  = 1'b1;
                  owner_d[i] = req_q.identifier;
                  ticks_d[i] = expire_q;
                end
              end
            end
          end
          KIND_REFRESH, KIND_RELEASE, KIND_QUERY_ID: begin
            if (hit) begin
              rsp_d.slot = hit_idx;
              rsp_d.ok   = 1'b1;
              for (int i = 0; i < SLOTS; i++) begin
                if (hit_idx == SLOT_W'(i)) begin
                  if (req_q.kind == KIND_REFRESH) begin
                    ticks_d[i] = expire_q;
                  end
                  if (req_q.kind == KIND_RELEASE) begin
                    used_d[i] = 1'b0;
                  end
                end
              end
            end
          end
          KIND_QUERY_SLOT: begin
            rsp_d.slot = req_q.slot_index;
            rsp_d.ok   = slot_reg;
          end
          default: begin
            out_valid_d = out_valid_q && !out_ready_i;
          end
        endcase
      end
      OP_TICK_START: begin
        cnt_d = '0;
        for (int i = 0; i < SLOTS; i++) begin
          exp_d[i] = used_q[i] && (ticks_q[i] == '0);
          if (used_q[i] && ticks_q[i] != '0) begin
            ticks_d[i] = ticks_q[i] - TICK_W'(1);
          end
        end
      end
      OP_EMIT_SEL: begin
        rsp_d.result_kind = RES_SELECT;
        rsp_d.slot        = sel_idx;
        rsp_d.ok          = 1'b0;
        rsp_d.last        = 1'b0;
        out_valid_d       = 1'b1;
      end
      OP_EMIT_UP: begin
        rsp_d.result_kind = RES_UP;
        rsp_d.slot        = sel_idx;
        rsp_d.ok          = 1'b0;
        rsp_d.last        = last_up;
        out_valid_d       = 1'b1;
        cnt_d             = cnt_q + CNT_W'(1);
        exp_d             = last_up ? '0 : exp_rest;
        for (int i = 0; i < SLOTS; i++) begin
          if (sel_idx == SLOT_W'(i)) begin
            used_d[i] = 1'b0;
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expire_q    <= EXPIRE_RESET;
      used_q      <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expire_q <= cfg_wdata_i;
      end
      used_q      <= used_d;
      exp_q       <= exp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    owner_q <= owner_d;
    ticks_q <= ticks_d;
    rsp_q   <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/touch_slot_allocator_top.sv =====
// Touch slot allocator: request in, responses and expiry events out.
// A request is loaded into the request register, then executed into the output
// register once it is free. No new request is taken until the last is done.
// Tick events go out one event per cycle while the output register is free.
// Reset clears all slots and loads the expiry time with 1000 ticks.
`default_nettype none
module touch_slot_allocator_top
  import tsa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [TICK_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire req_t              in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rsp_t                   out_rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== test/touch_slot_allocator_top_test.sv =====
// Self-checking testbench of the touch slot allocator: directed and random requests.
module touch_slot_allocator_top_test;
  import tsa_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int NO_SLOT       = -1;
  localparam int POOL_N        = 14;
  localparam int PHASE_ITEMS   = 22;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT   = 4000;
  localparam int IDLE_PERCENT  = 8;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [TICK_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  req_t              in_req_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  rsp_t              out_rsp_o;

  logic [ID_W-1:0]   slot_owner [SLOTS];
  logic              slot_live  [SLOTS];
  logic [TICK_W-1:0] slot_ttl   [SLOTS];
  logic [TICK_W-1:0] ttl_load = EXPIRE_RESET;

  rsp_t              due_rsp [$];
  req_t              pending_req [$];
  logic [ID_W-1:0]   id_pool [POOL_N];
  logic [TICK_W-1:0] ttl_steps [5] = '{16'd1, 16'hFFFF, 16'd2, 16'd3, 16'd0};

  int   fail_cnt     = 0;
  int   quiet_cycles = 0;
  int   hold_req     = 0;
  int   hold_seen    = 0;
  int   hold_left    = 0;
  logic calm         = 1'b0;
  logic req_taken    = 1'b0;

  touch_slot_allocator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic rsp_t make_rsp(logic [RES_W-1:0] k, int s, logic ok, logic last);
    rsp_t r;
    r.result_kind = k;
    r.slot        = SLOT_W'(s);
    r.ok          = ok;
    r.last        = last;
    return r;
  endfunction

  function automatic int owner_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (slot_live[i] && slot_owner[i] == id) return i;
    return NO_SLOT;
  endfunction

  task automatic expect_rsp(rsp_t r);
    due_rsp = {due_rsp, r};
  endtask

  task automatic apply_request(req_t r);
    int s;
    int due_events;
    int done;
    s = owner_slot(r.identifier);
    case (r.kind)
      KIND_ACQUIRE: begin
        if (s == NO_SLOT) begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!slot_live[i]) s = i;
          if (s != NO_SLOT) begin
            slot_live[s]  = 1'b1;
            slot_owner[s] = r.identifier;
            slot_ttl[s]   = ttl_load;
          end
        end
        expect_rsp(make_rsp(RES_RESPONSE, (s == NO_SLOT) ? 0 : s, s != NO_SLOT, 1'b1));
      end
      KIND_REFRESH, KIND_RELEASE, KIND_QUERY_ID: begin
        if (s != NO_SLOT && r.kind == KIND_REFRESH) slot_ttl[s] = ttl_load;
        if (s != NO_SLOT && r.kind == KIND_RELEASE) slot_live[s] = 1'b0;
        expect_rsp(make_rsp(RES_RESPONSE, (s == NO_SLOT) ? 0 : s, s != NO_SLOT, 1'b1));
      end
      KIND_QUERY_SLOT: begin
        expect_rsp(make_rsp(RES_RESPONSE, r.slot_index,
            (r.slot_index < SLOTS) ? slot_live[r.slot_index] : 1'b0, 1'b1));
      end
      KIND_TICK: begin
        due_events = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && slot_ttl[i] == '0) due_events++;
        if (due_events > MAX_EXPIRE) due_events = MAX_EXPIRE;
        done = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_live[i]) continue;
          if (slot_ttl[i] != '0) begin
            slot_ttl[i] = slot_ttl[i] - 1'b1;
          end else if (done < due_events) begin
            done++;
            expect_rsp(make_rsp(RES_SELECT, i, 1'b0, 1'b0));
            expect_rsp(make_rsp(RES_UP, i, 1'b0, done == due_events));
            slot_live[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : monitor
    rsp_t want;
    req_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) apply_request(in_req_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_rsp.size() == 0) begin
        $error("result with nothing expected: result_kind %0d slot %0d",
               out_rsp_o.result_kind, out_rsp_o.slot);
        fail_cnt++;
      end else begin
        want = due_rsp.pop_front();
        if (out_rsp_o.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, out_rsp_o.result_kind);
          fail_cnt++;
        end
        if (out_rsp_o.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_rsp_o.slot);
          fail_cnt++;
        end
        if (out_rsp_o.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_rsp_o.ok);
          fail_cnt++;
        end
        if (out_rsp_o.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_rsp_o.last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the request until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_req.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        in_req_i   <= pending_req.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic offer(logic [KIND_W-1:0] k, logic [ID_W-1:0] id, logic [SLOT_W-1:0] idx);
    req_t r;
    r.kind       = k;
    r.identifier = id;
    r.slot_index = idx;
    pending_req = {pending_req, r};
  endtask

  task automatic offer_random(int n);
    int made;
    int pick;
    logic [KIND_W-1:0] k;
    logic [ID_W-1:0] id;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      id = ($urandom_range(99) < 15) ? $urandom() : id_pool[$urandom_range(POOL_N - 1)];
      if (pick < 5) begin
        k = pick[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
      end else begin
        made++;
        if (pick < 35)      k = KIND_ACQUIRE;
        else if (pick < 50) k = KIND_REFRESH;
        else if (pick < 62) k = KIND_RELEASE;
        else if (pick < 72) k = KIND_QUERY_ID;
        else if (pick < 80) k = KIND_QUERY_SLOT;
        else                k = KIND_TICK;
      end
      offer(k, id, SLOT_W'($urandom_range(15)));
    end
  endtask

  task automatic settle();
    while (pending_req.size() != 0 || in_valid_i || due_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_expiry(logic [TICK_W-1:0] v);
    @(negedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    ttl_load    = v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : sequencer
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]  = 1'b0;
      slot_owner[i] = '0;
      slot_ttl[i]   = '0;
    end
    foreach (id_pool[i]) id_pool[i] = $urandom();
    id_pool[0] = '0;
    id_pool[1] = '1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    offer(KIND_QUERY_SLOT, '0, 4'd0);
    offer(KIND_QUERY_SLOT, '1, 4'd15);
    offer(KIND_QUERY_SLOT, '0, SLOT_W'(SLOTS));
    offer(KIND_QUERY_ID, id_pool[0], 4'd0);
    offer(KIND_REFRESH, id_pool[1], 4'd0);
    offer(KIND_RELEASE, id_pool[1], 4'd0);
    offer(KIND_TICK, '0, 4'd0);
    offer(KIND_SPARE_LO, '1, 4'd15);
    offer(KIND_SPARE_HI, '0, 4'd0);
    for (int i = 0; i < SLOTS; i++) offer(KIND_ACQUIRE, id_pool[i], 4'd0);
    offer(KIND_ACQUIRE, id_pool[0], 4'd0);
    offer(KIND_ACQUIRE, id_pool[10], 4'd0);
    offer(KIND_QUERY_SLOT, '0, SLOT_W'(SLOTS - 1));
    offer(KIND_REFRESH, id_pool[1], 4'd0);
    offer(KIND_QUERY_ID, id_pool[1], 4'd0);
    offer(KIND_RELEASE, id_pool[3], 4'd0);
    offer(KIND_ACQUIRE, id_pool[10], 4'd0);
    offer(KIND_TICK, '0, 4'd0);
    settle();

    // expire every slot in one tick
    write_expiry('0);
    for (int i = 0; i <= 10; i++) offer(KIND_REFRESH, id_pool[i], 4'd0);
    offer(KIND_TICK, '0, 4'd0);
    offer(KIND_TICK, '0, 4'd0);
    settle();

    foreach (ttl_steps[p]) begin
      write_expiry(ttl_steps[p]);
      calm = (p == 2);
      if (p == 3) hold_req = hold_req + 1;
      offer_random(PHASE_ITEMS);
      settle();
      calm = 1'b0;
    end

    if (fail_cnt == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule
